[hw/rtl/cigp_pkg.sv]
package cigp_pkg;

	localparam int NumPorts = 3;
	localparam int PortIdxW = 2;

	// Port that carries the three-button pad; a value of three leaves every port without one.
	localparam logic [PortIdxW-1:0] PadPort = 2'd0;

	localparam logic [7:0] ConnectedMask = 8'h7F;
	localparam logic [7:0] LatchReset    = 8'h7F;
	localparam logic [7:0] UnmappedRead  = 8'hFF;

	localparam logic [3:0] AddrData0 = 4'h3;
	localparam logic [3:0] AddrData1 = 4'h5;
	localparam logic [3:0] AddrData2 = 4'h7;
	localparam logic [3:0] AddrDir0  = 4'h9;
	localparam logic [3:0] AddrDir1  = 4'hB;
	localparam logic [3:0] AddrDir2  = 4'hD;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ACC_DATA,
		ACC_DIR,
		ACC_NONE
	} acc_kind_t;

	typedef struct packed {
		logic       req_type;
		logic [3:0] addr;
		logic [7:0] wdata;
		logic [7:0] buttons;
	} req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       unmapped;
	} rsp_t;

	typedef struct packed {
		logic [7:0] latch;
		logic [7:0] dir;
		logic       th;
		logic       has_pad;
	} port_view_t;

endpackage

[hw/rtl/console_io_port_gamepad_top.sv]
// Register block for three 8-bit console I/O ports, each with a data latch, a direction
// register and a latched TH select line, with a three-button pad wired to one port. Each
// request passes an input register and then a result register: the response is loaded as the
// request leaves the input register, which holds it while an earlier response waits unaccepted.
// A new request can be taken in every cycle while the response side keeps up. Register
// writes take effect in the cycle the request leaves the input register, so each request sees
// the effect of all earlier ones.
module console_io_port_gamepad_top
	import cigp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic                valid_s1;
	req_t                req_s1;
	logic                advance;

	logic [7:0]          data_latch_q [NumPorts];
	logic [7:0]          direction_q  [NumPorts];
	logic [NumPorts-1:0] select_q;

	logic [3:0]          addr_f;
	acc_kind_t           kind;
	logic [PortIdxW-1:0] port_idx;
	port_view_t          view;
	logic [7:0]          port_data;
	rsp_t                rsp_d;
	logic                is_write;

	assign advance   = !rsp_valid || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign addr_f    = req_s1.addr | 4'h1;
	assign is_write  = (req_s1.req_type == REQ_WRITE);

	always_comb begin
		kind     = ACC_NONE;
		port_idx = '0;
		unique case (addr_f)
			AddrData0: begin kind = ACC_DATA; port_idx = 2'd0; end
			AddrData1: begin kind = ACC_DATA; port_idx = 2'd1; end
			AddrData2: begin kind = ACC_DATA; port_idx = 2'd2; end
			AddrDir0:  begin kind = ACC_DIR;  port_idx = 2'd0; end
			AddrDir1:  begin kind = ACC_DIR;  port_idx = 2'd1; end
			AddrDir2:  begin kind = ACC_DIR;  port_idx = 2'd2; end
			default:   begin kind = ACC_NONE; port_idx = '0;   end
		endcase
	end

	always_comb begin
		view.latch   = data_latch_q[port_idx];
		view.dir     = direction_q[port_idx];
		view.th      = select_q[port_idx];
		view.has_pad = (port_idx == PadPort);
	end

	cigp_port_read u_port_read (
		.port    (view),
		.buttons (req_s1.buttons),
		.data    (port_data)
	);

	always_comb begin
		rsp_d.rdata    = 8'h00;
		rsp_d.unmapped = 1'b0;
		case (kind)
			ACC_DATA: rsp_d.rdata = is_write ? 8'h00 : port_data;
			ACC_DIR:  rsp_d.rdata = is_write ? 8'h00 : view.dir;
			default: begin
				rsp_d.unmapped = 1'b1;
				rsp_d.rdata    = is_write ? 8'h00 : UnmappedRead;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
			select_q  <= '0;
			for (int i = 0; i < NumPorts; i++) begin
				data_latch_q[i] <= LatchReset;
				direction_q[i]  <= 8'h00;
			end
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid <= valid_s1;
			end
			if (valid_s1 && advance && is_write) begin
				if (kind == ACC_DATA) begin
					data_latch_q[port_idx] <= req_s1.wdata;
					select_q[port_idx]     <= req_s1.wdata[6] & view.dir[6];
				end else if (kind == ACC_DIR) begin
					direction_q[port_idx] <= req_s1.wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance && valid_s1) begin
			rsp <= rsp_d;
		end
	end

endmodule

[hw/rtl/cigp_port_read.sv]
module cigp_port_read
	import cigp_pkg::*;
(
	input  port_view_t port,
	input  logic [7:0] buttons,
	output logic [7:0] data
);

	logic [7:0] pressed;
	logic [7:0] lines;
	logic [7:0] in_mask;

	always_comb begin
		pressed      = 8'h00;
		pressed[1:0] = buttons[1:0];
		if (port.th) begin
			pressed[3:2] = buttons[3:2];
			pressed[4]   = buttons[6];
			pressed[5]   = buttons[7];
		end else begin
			pressed[3:2] = 2'b11;
			pressed[4]   = buttons[5];
			pressed[5]   = buttons[4];
		end
		lines   = port.has_pad ? ~pressed : 8'hFF;
		in_mask = ~port.dir & ConnectedMask;
		data    = (lines & in_mask) | (port.latch & ~in_mask);
	end

endmodule
